FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/vlr3_pkg.sv
`timescale 1ns / 1ps

package vlr3_pkg;

   localparam int unsigned COLOUR_BITS = 24;
   localparam int unsigned NUM_AXES    = 3;

   // Axis positions inside the per-axis vectors.
   localparam int unsigned AXIS_X = 0;
   localparam int unsigned AXIS_Y = 1;
   localparam int unsigned AXIS_Z = 2;

   // Commands from the sequencer to the step unit.
   typedef struct packed {
      logic load;
      logic advance;
   } step_ctrl_type;

endpackage

FILE: sv/vlr3_ifs.sv
`timescale 1ns / 1ps

interface vlr3_req_if #(
   parameter int unsigned COORD_BITS = 3
) ();
   logic                               valid;
   logic                               ready;
   logic [COORD_BITS-1:0]              start_x;
   logic [COORD_BITS-1:0]              start_y;
   logic [COORD_BITS-1:0]              start_z;
   logic [COORD_BITS-1:0]              end_x;
   logic [COORD_BITS-1:0]              end_y;
   logic [COORD_BITS-1:0]              end_z;
   logic [vlr3_pkg::COLOUR_BITS-1:0]   colour;

   modport source (
      output valid, start_x, start_y, start_z, end_x, end_y, end_z, colour,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, start_z, end_x, end_y, end_z, colour,
      output ready
   );
endinterface

interface vlr3_rsp_if #(
   parameter int unsigned COORD_BITS = 3
) ();
   logic                               valid;
   logic                               ready;
   logic [COORD_BITS-1:0]              voxel_x;
   logic [COORD_BITS-1:0]              voxel_y;
   logic [COORD_BITS-1:0]              voxel_z;
   logic [vlr3_pkg::COLOUR_BITS-1:0]   voxel_colour;
   logic                               last_voxel;

   modport source (
      output valid, voxel_x, voxel_y, voxel_z, voxel_colour, last_voxel,
      input  ready
   );
   modport sink (
      input  valid, voxel_x, voxel_y, voxel_z, voxel_colour, last_voxel,
      output ready
   );
endinterface

FILE: sv/vlr3_setup.sv
`timescale 1ns / 1ps

module vlr3_setup #(
   parameter int unsigned COORD_BITS = 3
) (
   input  logic                                              clock,
   input  logic                                              capture,
   input  logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     start_pos_in,
   input  logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     end_pos_in,
   output logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     start_pos,
   output logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     mag,
   output logic [vlr3_pkg::NUM_AXES-1:0]                     neg,
   output logic [vlr3_pkg::NUM_AXES-1:0]                     major,
   output logic [COORD_BITS-1:0]                             mag_major,
   output logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS+2:0]     err_init
);

   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] start_ff;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] end_ff;

   always_ff @(posedge clock) begin
      if (capture) begin
         start_ff <= start_pos_in;
         end_ff   <= end_pos_in;
      end
   end

   assign start_pos = start_ff;

   // Per-axis absolute delta and direction.
   always_comb begin
      for (int i = 0; i < vlr3_pkg::NUM_AXES; i++) begin
         neg[i] = end_ff[i] < start_ff[i];
         mag[i] = neg[i] ? (start_ff[i] - end_ff[i]) : (end_ff[i] - start_ff[i]);
      end
   end

   // Driving axis: largest delta, ties resolved toward x, then y.
   always_comb begin
      major = '0;
      if ((mag[vlr3_pkg::AXIS_X] >= mag[vlr3_pkg::AXIS_Y]) &&
          (mag[vlr3_pkg::AXIS_X] >= mag[vlr3_pkg::AXIS_Z])) begin
         major[vlr3_pkg::AXIS_X] = 1'b1;
         mag_major               = mag[vlr3_pkg::AXIS_X];
      end else if (mag[vlr3_pkg::AXIS_Y] >= mag[vlr3_pkg::AXIS_Z]) begin
         major[vlr3_pkg::AXIS_Y] = 1'b1;
         mag_major               = mag[vlr3_pkg::AXIS_Y];
      end else begin
         major[vlr3_pkg::AXIS_Z] = 1'b1;
         mag_major               = mag[vlr3_pkg::AXIS_Z];
      end
   end

   // Initial error term, two's complement: twice the axis delta less the major delta.
   always_comb begin
      for (int i = 0; i < vlr3_pkg::NUM_AXES; i++) begin
         err_init[i] = {2'b00, mag[i], 1'b0} - {3'b000, mag_major};
      end
   end

endmodule

FILE: sv/vlr3_step.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vlr3_step #(
   parameter int unsigned COORD_BITS = 3
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  vlr3_pkg::step_ctrl_type                           ctrl,
   input  logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     start_pos,
   input  logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     mag,
   input  logic [vlr3_pkg::NUM_AXES-1:0]                     neg,
   input  logic [vlr3_pkg::NUM_AXES-1:0]                     major,
   input  logic [COORD_BITS-1:0]                             mag_major,
   input  logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS+2:0]     err_init,
   output logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0]     pos,
   output logic                                              last
);

   localparam int unsigned ERR_BITS = COORD_BITS + 3;

   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pos_ff;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pos_in;
   logic [vlr3_pkg::NUM_AXES-1:0][ERR_BITS-1:0]   err_ff;
   logic [vlr3_pkg::NUM_AXES-1:0][ERR_BITS-1:0]   err_in;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] mag_ff;
   logic [vlr3_pkg::NUM_AXES-1:0]                 neg_ff;
   logic [vlr3_pkg::NUM_AXES-1:0]                 major_ff;
   logic [COORD_BITS-1:0]                         mag_major_ff;
   logic [COORD_BITS-1:0]                         remain_ff;

   // One voxel step: each axis either moves one unit toward its endpoint or holds.
   always_comb begin
      for (int i = 0; i < vlr3_pkg::NUM_AXES; i++) begin
         logic err_pos;
         err_pos = !err_ff[i][ERR_BITS-1] && (err_ff[i] != '0);
         err_in[i] = err_ff[i] + {2'b00, mag_ff[i], 1'b0}
                     - (err_pos ? {2'b00, mag_major_ff, 1'b0} : '0);
         if (major_ff[i] || err_pos) begin
            pos_in[i] = neg_ff[i] ? (pos_ff[i] - 1'b1) : (pos_ff[i] + 1'b1);
         end else begin
            pos_in[i] = pos_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         major_ff  <= '0;
      end else if (ctrl.load) begin
         remain_ff <= mag_major;
         major_ff  <= major;
      end else if (ctrl.advance) begin
         remain_ff <= remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pos_ff       <= start_pos;
         err_ff       <= err_init;
         mag_ff       <= mag;
         neg_ff       <= neg;
         mag_major_ff <= mag_major;
      end else if (ctrl.advance) begin
         pos_ff <= pos_in;
         err_ff <= err_in;
      end
   end

   assign pos  = pos_ff;
   assign last = (remain_ff == '0);

   `ASSERT_NEXT(a_load_onehot_major, clock, reset, ctrl.load, $onehot(major_ff),
                "driving axis is not one-hot after load")
   `ASSERT_SAME(a_no_step_past_end, clock, reset, ctrl.advance, remain_ff != '0,
                "step requested after the final voxel")
   `ASSERT_NEXT(a_major_moves, clock, reset, ctrl.advance && !ctrl.load,
                remain_ff == ($past(remain_ff) - 1'b1),
                "voxel countdown did not decrement on a step")

endmodule

FILE: sv/voxel_line_rasterizer_3d.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Start-up: an accepted request is registered into SETUP, where the step unit loads,
// and the first voxel is offered in RUN, the state after SETUP.
// Throughput: one voxel per cycle while the sink is ready; a line gives
// (largest absolute delta + 1) voxels, at most 2^COORD_BITS, and the block
// returns to IDLE before the next request is taken.
// Reset: synchronous, active high; clears the sequencer and the voxel countdown.

module voxel_line_rasterizer_3d #(
   parameter int unsigned COORD_BITS = 3
) (
   input  logic              clock,
   input  logic              reset,
   vlr3_req_if.sink          req_if,
   vlr3_rsp_if.source        rsp_if
);

   // The sequencer walks through three phases. IDLE waits for a request,
   // SETUP lets the step unit load the deltas and initial error terms, and
   // RUN offers one voxel per cycle while the sink is ready, until the final voxel is taken.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic                                      req_fire;
   logic                                      rsp_fire;
   logic                                      step_last;
   logic [vlr3_pkg::COLOUR_BITS-1:0]          colour_ff;
   vlr3_pkg::step_ctrl_type                   step_ctrl;

   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] req_start;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] req_end;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] setup_start;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] setup_mag;
   logic [vlr3_pkg::NUM_AXES-1:0]                 setup_neg;
   logic [vlr3_pkg::NUM_AXES-1:0]                 setup_major;
   logic [COORD_BITS-1:0]                         setup_mag_major;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS+2:0] setup_err;
   logic [vlr3_pkg::NUM_AXES-1:0][COORD_BITS-1:0] voxel_pos;

   // A new request is taken only when no line is in progress.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;

   assign req_start[vlr3_pkg::AXIS_X] = req_if.start_x;
   assign req_start[vlr3_pkg::AXIS_Y] = req_if.start_y;
   assign req_start[vlr3_pkg::AXIS_Z] = req_if.start_z;
   assign req_end[vlr3_pkg::AXIS_X]   = req_if.end_x;
   assign req_end[vlr3_pkg::AXIS_Y]   = req_if.end_y;
   assign req_end[vlr3_pkg::AXIS_Z]   = req_if.end_z;

   // The colour simply rides along with the line.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         colour_ff <= req_if.colour;
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = req_fire ? ST_SETUP : ST_IDLE;
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            state_in = (rsp_fire && step_last) ? ST_IDLE : ST_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The step unit loads in SETUP and moves one voxel each time the current
   // voxel is taken, except after the final one.
   assign step_ctrl.load    = (state_ff == ST_SETUP);
   assign step_ctrl.advance = rsp_fire && !step_last;

   vlr3_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .clock        (clock),
      .capture      (req_fire),
      .start_pos_in (req_start),
      .end_pos_in   (req_end),
      .start_pos    (setup_start),
      .mag          (setup_mag),
      .neg          (setup_neg),
      .major        (setup_major),
      .mag_major    (setup_mag_major),
      .err_init     (setup_err)
   );

   vlr3_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (step_ctrl),
      .start_pos (setup_start),
      .mag       (setup_mag),
      .neg       (setup_neg),
      .major     (setup_major),
      .mag_major (setup_mag_major),
      .err_init  (setup_err),
      .pos       (voxel_pos),
      .last      (step_last)
   );

   // The step unit's position registers serve directly as the output register.
   assign rsp_if.valid        = (state_ff == ST_RUN);
   assign rsp_if.voxel_x      = voxel_pos[vlr3_pkg::AXIS_X];
   assign rsp_if.voxel_y      = voxel_pos[vlr3_pkg::AXIS_Y];
   assign rsp_if.voxel_z      = voxel_pos[vlr3_pkg::AXIS_Z];
   assign rsp_if.voxel_colour = colour_ff;
   assign rsp_if.last_voxel   = step_last;

   `ASSERT_NEXT(a_request_starts_setup, clock, reset, req_fire,
                (state_ff == ST_SETUP) && !rsp_if.valid,
                "accepted request did not enter setup")
   `ASSERT_NEXT(a_setup_offers_voxel, clock, reset, step_ctrl.load, rsp_if.valid,
                "no voxel offered after setup")
   `ASSERT_NEXT(a_last_frees_block, clock, reset, rsp_fire && step_last, req_if.ready,
                "block not ready for a new request after the final voxel")

endmodule

FILE: test/tb_voxel_line_rasterizer_3d.sv
`timescale 1ns / 1ps

// Self-checking bench for the 3D voxel line rasterizer. Line requests go in
// through the request channel. For every accepted request, a line walker in
// the bench computes the voxels that the block should emit. Each voxel that
// the block hands over is then compared with the oldest voxel still expected.
// Both channel sides idle in random bursts. The run ends with a stretch of
// back-to-back traffic and no stalls.

module tb_voxel_line_rasterizer_3d;

   localparam int unsigned COORD_BITS  = 3;
   localparam int          COORD_MASK  = (1 << COORD_BITS) - 1;
   // Worst correct run: every line at 8 voxels, every voxel behind the
   // longest sink stall, every request behind the longest sender gap.
   // The limit allows several times the length of that run.
   localparam int unsigned CYCLE_LIMIT = 600000;
   // Cycles to watch after the last expected voxel for stray output.
   localparam int unsigned TAIL_CYCLES = 2 * ((1 << COORD_BITS) + 2);

   typedef logic [COORD_BITS-1:0]            coord_type;
   typedef logic [vlr3_pkg::COLOUR_BITS-1:0] colour_type;

   // One line request as the request channel carries it.
   typedef struct {
      coord_type  sx, sy, sz;
      coord_type  ex, ey, ez;
      colour_type colour;
   } line_type;

   // One voxel as the response channel carries it.
   typedef struct {
      coord_type  x, y, z;
      colour_type colour;
      logic       last;
   } voxel_type;

   logic clock;
   logic reset;

   vlr3_req_if #(.COORD_BITS(COORD_BITS)) req ();
   vlr3_rsp_if #(.COORD_BITS(COORD_BITS)) rsp ();

   voxel_line_rasterizer_3d #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   // Voxels that the block still owes, oldest first.
   voxel_type pending_voxels[$];

   int unsigned error_count    = 0;
   int unsigned lines_sent     = 0;
   int unsigned voxels_checked = 0;
   int unsigned single_voxel_lines = 0;
   int unsigned driving_axis_count[vlr3_pkg::NUM_AXES] = '{default: 0};

   // Switches for the random idling on each side.
   bit sender_gaps_on = 1'b1;
   bit sink_stalls_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Walk one line the same way the block should. The axis with the largest
   // absolute delta drives, and ties go to x, then y, then z. Each of the other
   // axes keeps an error term that decides when it steps. Coordinates wrap at
   // the coordinate width. The expected voxels go to the back of the queue.
   function automatic void plot_line(input line_type ln);
      int        pos[vlr3_pkg::NUM_AXES];
      int        mag[vlr3_pkg::NUM_AXES];
      int        dir[vlr3_pkg::NUM_AXES];
      int        first[vlr3_pkg::NUM_AXES];
      int        second[vlr3_pkg::NUM_AXES];
      int        major, minor_b, minor_c;
      int        err_b, err_c;
      voxel_type v;

      first[vlr3_pkg::AXIS_X]  = int'(ln.sx);
      first[vlr3_pkg::AXIS_Y]  = int'(ln.sy);
      first[vlr3_pkg::AXIS_Z]  = int'(ln.sz);
      second[vlr3_pkg::AXIS_X] = int'(ln.ex);
      second[vlr3_pkg::AXIS_Y] = int'(ln.ey);
      second[vlr3_pkg::AXIS_Z] = int'(ln.ez);
      for (int k = 0; k < vlr3_pkg::NUM_AXES; k++) begin
         pos[k] = first[k];
         dir[k] = (second[k] < first[k]) ? -1 : 1;
         mag[k] = (second[k] < first[k]) ? first[k] - second[k] : second[k] - first[k];
      end

      if (mag[vlr3_pkg::AXIS_X] >= mag[vlr3_pkg::AXIS_Y] &&
          mag[vlr3_pkg::AXIS_X] >= mag[vlr3_pkg::AXIS_Z]) begin
         major = vlr3_pkg::AXIS_X; minor_b = vlr3_pkg::AXIS_Y; minor_c = vlr3_pkg::AXIS_Z;
      end else if (mag[vlr3_pkg::AXIS_Y] >= mag[vlr3_pkg::AXIS_Z]) begin
         major = vlr3_pkg::AXIS_Y; minor_b = vlr3_pkg::AXIS_X; minor_c = vlr3_pkg::AXIS_Z;
      end else begin
         major = vlr3_pkg::AXIS_Z; minor_b = vlr3_pkg::AXIS_Y; minor_c = vlr3_pkg::AXIS_X;
      end
      driving_axis_count[major]++;
      if (mag[major] == 0)
         single_voxel_lines++;

      err_b = 2 * mag[minor_b] - mag[major];
      err_c = 2 * mag[minor_c] - mag[major];

      for (int i = 0; i <= mag[major]; i++) begin
         v.x      = coord_type'(pos[vlr3_pkg::AXIS_X]);
         v.y      = coord_type'(pos[vlr3_pkg::AXIS_Y]);
         v.z      = coord_type'(pos[vlr3_pkg::AXIS_Z]);
         v.colour = ln.colour;
         v.last   = (i == mag[major]);
         pending_voxels.push_back(v);
         if (i == mag[major])
            break;
         // A minor axis steps when its error term has gone positive.
         if (err_b > 0) begin
            pos[minor_b] = (pos[minor_b] + dir[minor_b]) & COORD_MASK;
            err_b -= 2 * mag[major];
         end
         if (err_c > 0) begin
            pos[minor_c] = (pos[minor_c] + dir[minor_c]) & COORD_MASK;
            err_c -= 2 * mag[major];
         end
         err_b += 2 * mag[minor_b];
         err_c += 2 * mag[minor_c];
         pos[major] = (pos[major] + dir[major]) & COORD_MASK;
      end
   endfunction

   function automatic line_type make_line(input int sx, sy, sz, ex, ey, ez,
                                          input colour_type colour);
      line_type ln;
      ln.sx = coord_type'(sx); ln.sy = coord_type'(sy); ln.sz = coord_type'(sz);
      ln.ex = coord_type'(ex); ln.ey = coord_type'(ey); ln.ez = coord_type'(ez);
      ln.colour = colour;
      return ln;
   endfunction

   // Random endpoints anywhere in the cube. About one request in eight
   // repeats the first endpoint as the second, so that single-voxel lines
   // keep showing up.
   function automatic line_type random_line();
      line_type ln;
      ln.sx = coord_type'($urandom);
      ln.sy = coord_type'($urandom);
      ln.sz = coord_type'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         ln.ex = ln.sx; ln.ey = ln.sy; ln.ez = ln.sz;
      end else begin
         ln.ex = coord_type'($urandom);
         ln.ey = coord_type'($urandom);
         ln.ez = coord_type'($urandom);
      end
      ln.colour = colour_type'($urandom);
      return ln;
   endfunction

   // Send one request. Inputs change only at falling edges. The request is
   // accepted at the first rising edge with ready high. Valid stays high when
   // this task returns, so back-to-back requests never drop it. A random gap
   // lowers it first.
   task automatic send_line(input line_type ln);
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req.valid   = 1'b1;
      req.start_x = ln.sx;
      req.start_y = ln.sy;
      req.start_z = ln.sz;
      req.end_x   = ln.ex;
      req.end_y   = ln.ey;
      req.end_z   = ln.ez;
      req.colour  = ln.colour;
      do @(posedge clock); while (!req.ready);
      plot_line(ln);
      lines_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_voxels.size() != 0)
         @(posedge clock);
   endtask

   // Directed lines: single voxels at both corners, the full diagonal both
   // ways, each axis driving alone and with the others in tow, every tie in
   // the choice of driving axis, steps toward lower coordinates, and colours
   // with all bits low, all bits high and alternating bits.
   task automatic test_directed_lines();
      send_line(make_line(0, 0, 0, 0, 0, 0, 24'h000000));
      send_line(make_line(7, 7, 7, 7, 7, 7, 24'hFFFFFF));
      send_line(make_line(0, 0, 0, 7, 7, 7, 24'hAAAAAA));
      send_line(make_line(7, 7, 7, 0, 0, 0, 24'h555555));
      send_line(make_line(0, 0, 0, 7, 0, 0, 24'hFF0000));
      send_line(make_line(0, 0, 0, 0, 7, 0, 24'h00FF00));
      send_line(make_line(0, 0, 0, 0, 0, 7, 24'h0000FF));
      send_line(make_line(7, 3, 3, 0, 3, 3, 24'h123456));
      send_line(make_line(0, 3, 5, 7, 6, 2, 24'hFEDCBA));
      send_line(make_line(2, 0, 6, 5, 7, 1, 24'h800001));
      send_line(make_line(6, 1, 0, 3, 4, 7, 24'h7FFFFE));
      send_line(make_line(1, 1, 1, 5, 5, 2, 24'hAAAAAA));
      send_line(make_line(3, 0, 0, 3, 6, 6, 24'h555555));
      send_line(make_line(0, 4, 0, 5, 4, 5, 24'h0F0F0F));
      send_line(make_line(7, 0, 7, 0, 7, 0, 24'hF0F0F0));
      send_line(make_line(0, 7, 0, 7, 0, 7, 24'h000001));
      send_line(make_line(4, 2, 1, 5, 3, 2, 24'h800000));
      send_line(make_line(3, 3, 3, 3, 3, 2, 24'hFFFFFF));
      send_line(make_line(0, 0, 0, 7, 1, 2, 24'h000000));
      send_line(make_line(7, 6, 5, 0, 1, 2, 24'h3C3C3C));
   endtask

   task automatic test_random_lines(input int unsigned count);
      repeat (count) send_line(random_line());
   endtask

   // The sender holds off until the block has handed over every voxel, so
   // the next request reaches a block that has gone fully idle.
   task automatic test_drain_and_resume();
      repeat (20) send_line(random_line());
      stop_sending();
      wait_for_drain();
      repeat (20) send_line(random_line());
   endtask

   // Last part: both sides always ready, so requests and voxels go back to back.
   task automatic test_back_to_back();
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      repeat (60) send_line(random_line());
   endtask

   // Response ready. It changes at falling edges. Stalls come in bursts,
   // with long ready stretches between them.
   initial begin : sink_ready_driver
      int unsigned stall_left;
      stall_left = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (!sink_stalls_on) begin
            rsp.ready = 1'b1;
         end else if (stall_left != 0) begin
            rsp.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp.ready  = 1'b0;
            stall_left = $urandom_range(0, 16);
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: voxel %0d field %s mismatch, expected %0h, actual %0h",
                  $time, voxels_checked, field, want, got);
         error_count++;
      end
   endfunction

   // Each voxel that the block hands over is checked against the oldest one
   // expected, field by field.
   always @(posedge clock) begin : voxel_checker
      voxel_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_voxels.size() == 0) begin
            $display("%0t: unexpected voxel, expected none, %s x=%0d y=%0d z=%0d c=%06h l=%0b",
                     $time, "actual", rsp.voxel_x, rsp.voxel_y, rsp.voxel_z,
                     rsp.voxel_colour, rsp.last_voxel);
            error_count++;
         end else begin
            want = pending_voxels.pop_front();
            compare_field("voxel_x", 32'(want.x), 32'(rsp.voxel_x));
            compare_field("voxel_y", 32'(want.y), 32'(rsp.voxel_y));
            compare_field("voxel_z", 32'(want.z), 32'(rsp.voxel_z));
            compare_field("voxel_colour", 32'(want.colour), 32'(rsp.voxel_colour));
            compare_field("last_voxel", 32'(want.last), 32'(rsp.last_voxel));
            voxels_checked++;
         end
      end
   end

   // A hung run ends here.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timed out with %0d voxels still expected", $time,
               pending_voxels.size());
      $display("FAILURE");
      $finish;
   end

   initial begin : main_sequence
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.start_x = '0;
      req.start_y = '0;
      req.start_z = '0;
      req.end_x   = '0;
      req.end_y   = '0;
      req.end_z   = '0;
      req.colour  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_lines();
      test_random_lines(400);
      test_drain_and_resume();
      test_back_to_back();
      stop_sending();

      // Let the block finish the last line. Then watch for a while longer
      // so that any stray voxel is caught.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending_voxels.size() != 0) begin
         $display("%0t: %0d voxels expected but never delivered", $time,
                  pending_voxels.size());
         error_count++;
      end

      $display("Rasterized %0d lines into %0d checked voxels, %0d single-voxel lines.",
               lines_sent, voxels_checked, single_voxel_lines);
      $display("Driving axis x/y/z on %0d/%0d/%0d lines, %0d mismatches.",
               driving_axis_count[vlr3_pkg::AXIS_X], driving_axis_count[vlr3_pkg::AXIS_Y],
               driving_axis_count[vlr3_pkg::AXIS_Z], error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
